### hdl/aimq_pkg.sv
// ----------------------------------------------------------------------------
// aimq_pkg: shared types and constants for the active interval max query
// Sizes, command codes and the structs that pass between the sequencer,
// the height memory and the top level.
// ----------------------------------------------------------------------------
package aimq_pkg;

   // Sizes
   localparam int MEMBER_SLOTS     = 64;
   localparam int SLOT_BITS        = $clog2(MEMBER_SLOTS);
   localparam int HEIGHT_BITS      = 30;
   localparam int TAG_BITS         = 6;
   localparam int QUERY_INDEX_BITS = 6;
   localparam int CMD_BITS         = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

   typedef logic [SLOT_BITS-1:0]   slot_idx_type;
   typedef logic [HEIGHT_BITS-1:0] height_type;

   localparam slot_idx_type LAST_SLOT = slot_idx_type'(MEMBER_SLOTS - 1);

   // Height memory access for one cycle
   typedef struct packed {
      logic         wr_en;
      slot_idx_type wr_addr;
      height_type   wr_data;
      slot_idx_type rd_addr;
   } mem_req_type;

   // Finished query result handed to the output register
   typedef struct packed {
      logic                        valid;
      logic                        answer;
      logic [QUERY_INDEX_BITS-1:0] query_index;
   } result_type;

   // True when a tag names an existing member slot
   function automatic logic slot_in_range(input logic [TAG_BITS-1:0] tag);
      return 32'(tag) < 32'(MEMBER_SLOTS);
   endfunction

endpackage

### hdl/active_interval_max_threshold_query.sv
// ----------------------------------------------------------------------------
// active_interval_max_threshold_query: threshold query over active members
// Start events record member heights, end events retire members for good,
// and a query answers whether every counting member is below its height.
//
//   channel | direction | ports
//   req     | in        | req_valid/req_ready, req_command, req_height, req_tag
//   rsp     | out       | rsp_valid/rsp_ready, rsp_answer, rsp_query_index
//
// An end event sets its retired flag in S_IDLE; a start event reads in
// S_IDLE, then compares and writes back in S_START_CMP. A query passes every
// slot in turn through the single height memory read port and one comparator.
// Reset clears the active and retired flags at once; no clearing pass.
// A finished result waits in the output register, so a stalled rsp side
// holds back only a query that finishes while the previous word is unread.
// ----------------------------------------------------------------------------
module active_interval_max_threshold_query (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [aimq_pkg::CMD_BITS-1:0]         req_command,
   input  logic [aimq_pkg::HEIGHT_BITS-1:0]      req_height,
   input  logic [aimq_pkg::TAG_BITS-1:0]         req_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_answer,
   output logic [aimq_pkg::QUERY_INDEX_BITS-1:0] rsp_query_index
);

   aimq_pkg::mem_req_type                mem_req;
   aimq_pkg::height_type                 mem_rd_data;
   aimq_pkg::result_type                 result;
   logic                                 rsp_free;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_answer_ff, rsp_answer_in;
   logic [aimq_pkg::QUERY_INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;

   aimq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_height  (req_height),
      .req_tag     (req_tag),
      .rsp_free    (rsp_free),
      .result      (result),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   aimq_height_mem u_height_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // Output word register: load a new result or drop the taken word
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_index_in  = rsp_index_ff;
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_answer_in = result.answer;
         rsp_index_in  = result.query_index;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_answer_ff <= rsp_answer_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_answer      = rsp_answer_ff;
   assign rsp_query_index = rsp_index_ff;

endmodule

### hdl/aimq_height_mem.sv
// ----------------------------------------------------------------------------
// aimq_height_mem: member height store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module aimq_height_mem (
   input  logic                 clock,
   input  aimq_pkg::mem_req_type mem_req,
   output aimq_pkg::height_type rd_data
);

   aimq_pkg::height_type mem [aimq_pkg::MEMBER_SLOTS];
   aimq_pkg::height_type rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/aimq_ctrl.sv
// ----------------------------------------------------------------------------
// aimq_ctrl: event sequencer with shared height comparator
// Keeps the active and retired flags, updates heights on start and sweeps
// all slots through one comparator on a query.
// ----------------------------------------------------------------------------
module aimq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [aimq_pkg::CMD_BITS-1:0]        req_command,
   input  aimq_pkg::height_type                 req_height,
   input  logic [aimq_pkg::TAG_BITS-1:0]        req_tag,
   input  logic                                 rsp_free,
   output aimq_pkg::result_type                 result,
   output aimq_pkg::mem_req_type                mem_req,
   input  aimq_pkg::height_type                 mem_rd_data
);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_START_CMP = 5'b00010,
      S_SCAN      = 5'b00100,
      S_DRAIN     = 5'b01000,
      S_REPLY     = 5'b10000
   } state_type;

   state_type                             state_ff, state_in;
   aimq_pkg::height_type                  height_ff, height_in;
   logic [aimq_pkg::TAG_BITS-1:0]         tag_ff, tag_in;
   aimq_pkg::slot_idx_type                scan_ff, scan_in;
   logic                                  pend_ff, pend_in;
   logic                                  pend_flag_ff, pend_flag_in;
   logic                                  found_ff, found_in;
   logic [aimq_pkg::MEMBER_SLOTS-1:0]     active_ff, active_in;
   logic [aimq_pkg::MEMBER_SLOTS-1:0]     retired_ff, retired_in;

   logic                                  accept;
   logic                                  ge;
   aimq_pkg::slot_idx_type                req_idx;
   aimq_pkg::slot_idx_type                hold_idx;
   logic [aimq_pkg::MEMBER_SLOTS-1:0]     counting;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_idx   = req_tag[aimq_pkg::SLOT_BITS-1:0];
   assign hold_idx  = tag_ff[aimq_pkg::SLOT_BITS-1:0];
   assign counting  = active_ff & ~retired_ff;

   // Shared comparator: stored height against held height
   assign ge = (mem_rd_data >= height_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      height_in      = height_ff;
      tag_in         = tag_ff;
      scan_in        = scan_ff;
      pend_in        = (state_ff == S_SCAN);
      pend_flag_in   = pend_flag_ff;
      found_in       = found_ff;
      active_in      = active_ff;
      retired_in     = retired_ff;
      result.valid   = 1'b0;
      result.answer      = !found_ff;
      result.query_index = tag_ff[aimq_pkg::QUERY_INDEX_BITS-1:0];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = hold_idx;
      mem_req.wr_data = height_ff;
      mem_req.rd_addr = scan_ff;

      // Fold in the compare of the slot read last cycle
      if (pend_ff && pend_flag_ff && ge) begin
         found_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            mem_req.rd_addr = req_idx;
            if (accept) begin
               height_in = req_height;
               tag_in    = req_tag;
               case (req_command)
                  aimq_pkg::CMD_START: begin
                     if (aimq_pkg::slot_in_range(req_tag)) begin
                        state_in = S_START_CMP;
                     end
                  end
                  aimq_pkg::CMD_END: begin
                     if (aimq_pkg::slot_in_range(req_tag)) begin
                        retired_in[req_idx] = 1'b1;
                     end
                  end
                  aimq_pkg::CMD_QUERY: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START_CMP: begin
            // Keep the larger height of an already active slot
            if (!active_ff[hold_idx] || !ge) begin
               mem_req.wr_en = 1'b1;
            end
            active_in[hold_idx] = 1'b1;
            state_in            = S_IDLE;
         end
         S_SCAN: begin
            mem_req.rd_addr = scan_ff;
            pend_flag_in    = counting[scan_ff];
            scan_in         = scan_ff + aimq_pkg::SLOT_BITS'(1);
            if (scan_ff == aimq_pkg::LAST_SLOT) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) begin
               result.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pend_ff    <= 1'b0;
         active_ff  <= '0;
         retired_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         active_ff  <= active_in;
         retired_ff <= retired_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      height_ff    <= height_in;
      tag_ff       <= tag_in;
      scan_ff      <= scan_in;
      pend_flag_ff <= pend_flag_in;
      found_ff     <= found_in;
   end

`ifndef SYNTHESIS
   a_query_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == aimq_pkg::CMD_QUERY) |=>
         (state_ff == S_SCAN) && (scan_ff == '0))
      else $error("query did not start a sweep at slot zero");

   a_scan_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && (scan_ff != aimq_pkg::LAST_SLOT) |=>
         (state_ff == S_SCAN) &&
         (scan_ff == aimq_pkg::SLOT_BITS'($past(scan_ff) + 1'b1)))
      else $error("sweep skipped or stalled");

   a_retired_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(retired_ff) & ~retired_ff) == '0))
      else $error("retired flag cleared");

   a_active_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(active_ff) & ~active_ff) == '0))
      else $error("active flag cleared");

   a_reply_after_drain: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> $past(state_ff == S_DRAIN) || $past(state_ff == S_REPLY))
      else $error("result issued without a finished sweep");
`endif

endmodule
